[rtl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked outside reset.
`define VNA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every edge, reset included.
`define VNA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/vna_pkg.sv]
package vna_pkg;

  localparam int NUM_VERT = 1024;
  localparam int VIDX_W   = $clog2(NUM_VERT);
  localparam int IDX_W    = 10;   // index field width on the ports
  localparam int POS_W    = 16;
  localparam int NRM_W    = 16;
  localparam int WORD_W   = 3 * 16;
  localparam int VEC_W    = 35;   // cross product / sum operand width
  localparam int UNIT_Q14 = 16384;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_TRI  = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  typedef enum logic [3:0] {
    T_IDLE, T_RDOUT, T_PA, T_PB, T_PC, T_PD, T_CROSS, T_FSTART, T_FWAIT,
    T_CRD, T_CSUM, T_CWAIT, T_CEMIT
  } top_state_t;

  typedef enum logic [2:0] {
    N_IDLE, N_SHIFT, N_SQ, N_SQRT, N_DINIT, N_DIV, N_DONE
  } norm_state_t;

  typedef struct packed {
    logic                    start;
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] z;
  } norm_req_t;

  typedef struct packed {
    logic                    done;
    logic                    zero;
    logic signed [NRM_W-1:0] x;
    logic signed [NRM_W-1:0] y;
    logic signed [NRM_W-1:0] z;
  } norm_rsp_t;

endpackage

[rtl/vna_if.sv]
interface vna_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        action;
  logic [vna_pkg::IDX_W-1:0]         vertex_index;
  logic signed [vna_pkg::POS_W-1:0]  pos_x;
  logic signed [vna_pkg::POS_W-1:0]  pos_y;
  logic signed [vna_pkg::POS_W-1:0]  pos_z;
  logic [vna_pkg::IDX_W-1:0]         corner_a;
  logic [vna_pkg::IDX_W-1:0]         corner_b;
  logic [vna_pkg::IDX_W-1:0]         corner_c;
  modport source (output valid, action, vertex_index, pos_x, pos_y, pos_z,
                  corner_a, corner_b, corner_c, input ready);
  modport sink   (input valid, action, vertex_index, pos_x, pos_y, pos_z,
                  corner_a, corner_b, corner_c, output ready);
endinterface

interface vna_out_if;
  logic                              valid;
  logic                              ready;
  logic [vna_pkg::IDX_W-1:0]         out_vertex;
  logic signed [vna_pkg::NRM_W-1:0]  norm_x;
  logic signed [vna_pkg::NRM_W-1:0]  norm_y;
  logic signed [vna_pkg::NRM_W-1:0]  norm_z;
  logic                              degenerate;
  logic                              last;
  modport source (output valid, out_vertex, norm_x, norm_y, norm_z, degenerate,
                  last, input ready);
  modport sink   (input valid, out_vertex, norm_x, norm_y, norm_z, degenerate,
                  last, output ready);
endinterface

[rtl/vertex_normal_accumulator.sv]
// Channel  Dir  Payload                                      Handshake
// in_if    in   action, vertex_index, pos_x/y/z, corner_a/b/c valid/ready
// out_if   out  out_vertex, norm_x/y/z, degenerate, last      valid/ready
//
// Load writes the position and zeroes the stored normal; read returns the
// stored normal once the output is free. Triangle: position reads, cross
// product, then four shared-normaliser passes, face first, then each corner
// (3 squares, 32 square-root steps, 15 division steps; a zero vector skips).
// One transaction in flight; in_if.ready is high only in the idle state.
// Results wait in the output register; the block stalls before overwriting it.
// Reset clears control only; both stores hold rubbish until written.
module vertex_normal_accumulator (
  input  logic      clk,
  input  logic      rst_n,
  vna_in_if.sink    in_if,
  vna_out_if.source out_if
);
  localparam int AW = vna_pkg::VIDX_W;

  vna_pkg::top_state_t state_r, state_nxt;

  logic [vna_pkg::IDX_W-1:0]  corner_r [3];
  logic [vna_pkg::IDX_W-1:0]  vidx_r;
  logic [1:0]                 k_r;
  logic [1:0]                 cnt_r;
  logic [47:0]                pa_r, pb_r, pc_r;
  logic signed [34:0]         cr_r [3];
  logic signed [15:0]         face_r [3];
  logic                       flat_r;

  // output register
  logic                       out_valid_r;
  logic [vna_pkg::IDX_W-1:0]  out_vertex_r;
  logic [47:0]                out_norm_r;
  logic                       out_degen_r, out_last_r;

  // memories
  logic          pos_we, pos_re, nrm_we, nrm_re;
  logic [AW-1:0] pos_waddr, pos_raddr, nrm_waddr, nrm_raddr;
  logic [47:0]   pos_rdata, nrm_wdata, nrm_rdata;

  vna_pkg::norm_req_t nreq;
  vna_pkg::norm_rsp_t nrsp;

  logic in_acc, out_free, load_out, cross_done;

  assign in_acc   = in_if.valid && in_if.ready;
  assign out_free = !out_valid_r || out_if.ready;

  vna_ram #(.WIDTH(vna_pkg::WORD_W), .DEPTH(vna_pkg::NUM_VERT)) u_pos_ram (
    .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata({in_if.pos_x, in_if.pos_y, in_if.pos_z}),
    .re(pos_re), .raddr(pos_raddr), .rdata(pos_rdata)
  );

  vna_ram #(.WIDTH(vna_pkg::WORD_W), .DEPTH(vna_pkg::NUM_VERT)) u_nrm_ram (
    .clk(clk), .we(nrm_we), .waddr(nrm_waddr), .wdata(nrm_wdata),
    .re(nrm_re), .raddr(nrm_raddr), .rdata(nrm_rdata)
  );

  vna_norm u_norm (.clk(clk), .rst_n(rst_n), .req(nreq), .rsp(nrsp));

  // Edges from corner a and one pair of cross-product terms per cycle
  function automatic logic signed [16:0] sx17(logic [15:0] v);
    return {v[15], v};
  endfunction

  logic signed [16:0] e1 [3];
  logic signed [16:0] e2 [3];
  logic signed [16:0] ma, mb, mc, md;
  logic signed [33:0] p1, p2;
  logic signed [34:0] cr_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1[i] = sx17(pb_r[47-16*i -: 16]) - sx17(pa_r[47-16*i -: 16]);
      e2[i] = sx17(pc_r[47-16*i -: 16]) - sx17(pa_r[47-16*i -: 16]);
    end
    unique case (cnt_r)
      2'd0:    begin ma = e1[1]; mb = e2[2]; mc = e1[2]; md = e2[1]; end
      2'd1:    begin ma = e1[2]; mb = e2[0]; mc = e1[0]; md = e2[2]; end
      default: begin ma = e1[0]; mb = e2[1]; mc = e1[1]; md = e2[0]; end
    endcase
    p1     = ma * mb;
    p2     = mc * md;
    cr_nxt = 35'(p1) - 35'(p2);
  end

  assign cross_done = (cnt_r == 2'd2);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vna_pkg::T_IDLE: if (in_acc) begin
        unique case (in_if.action)
          vna_pkg::ACT_TRI:  state_nxt = vna_pkg::T_PA;
          vna_pkg::ACT_READ: state_nxt = vna_pkg::T_RDOUT;
          default:           state_nxt = vna_pkg::T_IDLE;
        endcase
      end
      vna_pkg::T_RDOUT:  if (out_free) state_nxt = vna_pkg::T_IDLE;
      vna_pkg::T_PA:     state_nxt = vna_pkg::T_PB;
      vna_pkg::T_PB:     state_nxt = vna_pkg::T_PC;
      vna_pkg::T_PC:     state_nxt = vna_pkg::T_PD;
      vna_pkg::T_PD:     state_nxt = vna_pkg::T_CROSS;
      vna_pkg::T_CROSS:  if (cross_done) state_nxt = vna_pkg::T_FSTART;
      vna_pkg::T_FSTART: state_nxt = vna_pkg::T_FWAIT;
      vna_pkg::T_FWAIT:  if (nrsp.done) state_nxt = vna_pkg::T_CRD;
      vna_pkg::T_CRD:    state_nxt = vna_pkg::T_CSUM;
      vna_pkg::T_CSUM:   state_nxt = vna_pkg::T_CWAIT;
      vna_pkg::T_CWAIT:  if (nrsp.done) state_nxt = vna_pkg::T_CEMIT;
      vna_pkg::T_CEMIT:  if (out_free) begin
        state_nxt = (k_r == 2'd2) ? vna_pkg::T_IDLE : vna_pkg::T_CRD;
      end
      default:           state_nxt = vna_pkg::T_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_if.ready = (state_r == vna_pkg::T_IDLE);
    pos_we      = (state_r == vna_pkg::T_IDLE) && in_acc && (in_if.action == vna_pkg::ACT_LOAD);
    pos_waddr   = in_if.vertex_index[AW-1:0];
    pos_re      = (state_r == vna_pkg::T_PA) || (state_r == vna_pkg::T_PB) ||
                  (state_r == vna_pkg::T_PC);
    unique case (state_r)
      vna_pkg::T_PA: pos_raddr = corner_r[0][AW-1:0];
      vna_pkg::T_PB: pos_raddr = corner_r[1][AW-1:0];
      default:       pos_raddr = corner_r[2][AW-1:0];
    endcase

    load_out  = out_free &&
                ((state_r == vna_pkg::T_RDOUT) || (state_r == vna_pkg::T_CEMIT));
    nrm_we    = pos_we || ((state_r == vna_pkg::T_CEMIT) && out_free);
    nrm_waddr = pos_we ? in_if.vertex_index[AW-1:0] : corner_r[k_r][AW-1:0];
    nrm_wdata = pos_we ? '0 : {nrsp.x, nrsp.y, nrsp.z};
    nrm_re    = ((state_r == vna_pkg::T_IDLE) && in_acc &&
                 (in_if.action == vna_pkg::ACT_READ)) || (state_r == vna_pkg::T_CRD);
    nrm_raddr = (state_r == vna_pkg::T_IDLE) ? in_if.vertex_index[AW-1:0]
                                             : corner_r[k_r][AW-1:0];

    nreq.start = (state_r == vna_pkg::T_FSTART) || (state_r == vna_pkg::T_CSUM);
    if (state_r == vna_pkg::T_CSUM) begin
      // stored normal plus face normal
      nreq.x = 35'($signed(nrm_rdata[47:32])) + 35'(face_r[0]);
      nreq.y = 35'($signed(nrm_rdata[31:16])) + 35'(face_r[1]);
      nreq.z = 35'($signed(nrm_rdata[15:0]))  + 35'(face_r[2]);
    end else begin
      nreq.x = cr_r[0];
      nreq.y = cr_r[1];
      nreq.z = cr_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vna_pkg::T_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      corner_r[0] <= in_if.corner_a;
      corner_r[1] <= in_if.corner_b;
      corner_r[2] <= in_if.corner_c;
      vidx_r      <= in_if.vertex_index;
    end
    unique case (state_r)
      vna_pkg::T_PB: pa_r <= pos_rdata;
      vna_pkg::T_PC: pb_r <= pos_rdata;
      vna_pkg::T_PD: begin
        pc_r  <= pos_rdata;
        cnt_r <= '0;
      end
      vna_pkg::T_CROSS: begin
        cr_r[cnt_r] <= cr_nxt;
        cnt_r       <= cnt_r + 2'd1;
      end
      vna_pkg::T_FWAIT: if (nrsp.done) begin
        face_r[0] <= nrsp.x;
        face_r[1] <= nrsp.y;
        face_r[2] <= nrsp.z;
        flat_r    <= nrsp.zero;
        k_r       <= '0;
      end
      vna_pkg::T_CEMIT: if (out_free) k_r <= k_r + 2'd1;
      default: ;
    endcase

    if (load_out) begin
      if (state_r == vna_pkg::T_RDOUT) begin
        out_vertex_r <= vidx_r;
        out_norm_r   <= nrm_rdata;
        out_degen_r  <= 1'b0;
        out_last_r   <= 1'b1;
      end else begin
        out_vertex_r <= corner_r[k_r];
        out_norm_r   <= {nrsp.x, nrsp.y, nrsp.z};
        out_degen_r  <= flat_r || nrsp.zero;
        out_last_r   <= (k_r == 2'd2);
      end
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.out_vertex = out_vertex_r;
  assign out_if.norm_x     = out_norm_r[47:32];
  assign out_if.norm_y     = out_norm_r[31:16];
  assign out_if.norm_z     = out_norm_r[15:0];
  assign out_if.degenerate = out_degen_r;
  assign out_if.last       = out_last_r;
endmodule

[rtl/vna_ram.sv]
module vna_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[rtl/vna_norm.sv]
module vna_norm (
  input  logic                clk,
  input  logic                rst_n,
  input  vna_pkg::norm_req_t  req,
  output vna_pkg::norm_rsp_t  rsp
);
  vna_pkg::norm_state_t state_r, state_nxt;

  logic [34:0] mag_r [3];
  logic        neg_r [3];
  logic        zero_r;
  logic [61:0] sum_r;      // sum of squares, then radicand remainder
  logic [62:0] res_r;
  logic [62:0] bit_r;
  logic [3:0]  cnt_r;
  logic [31:0] rq_r  [3];
  logic [14:0] lo_r  [3];
  logic [14:0] q_r   [3];

  logic [34:0] mx;
  logic [2:0]  sh;
  logic [29:0] sq_in;
  logic [59:0] sq;
  logic [63:0] trial;
  logic        ge;
  logic [32:0] den;

  always_comb begin
    mx = mag_r[0];
    if (mag_r[1] > mx) mx = mag_r[1];
    if (mag_r[2] > mx) mx = mag_r[2];
    priority if (mx[34]) sh = 3'd5;
    else if (mx[33])     sh = 3'd4;
    else if (mx[32])     sh = 3'd3;
    else if (mx[31])     sh = 3'd2;
    else if (mx[30])     sh = 3'd1;
    else                 sh = 3'd0;
    sq_in = mag_r[cnt_r[1:0]][29:0];
    sq    = sq_in * sq_in;
    trial = {1'b0, res_r} + {1'b0, bit_r};
    ge    = {2'b00, sum_r} >= trial;
    den   = {1'b0, res_r[30:0], 1'b0};
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vna_pkg::N_IDLE:  if (req.start) state_nxt = vna_pkg::N_SHIFT;
      vna_pkg::N_SHIFT: state_nxt = (mx == '0) ? vna_pkg::N_DONE : vna_pkg::N_SQ;
      vna_pkg::N_SQ:    if (cnt_r == 4'd2) state_nxt = vna_pkg::N_SQRT;
      vna_pkg::N_SQRT:  if (bit_r[0]) state_nxt = vna_pkg::N_DINIT;
      vna_pkg::N_DINIT: state_nxt = vna_pkg::N_DIV;
      vna_pkg::N_DIV:   if (cnt_r == 4'd14) state_nxt = vna_pkg::N_DONE;
      vna_pkg::N_DONE:  state_nxt = vna_pkg::N_IDLE;
      default:          state_nxt = vna_pkg::N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vna_pkg::N_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    logic [45:0] num;
    logic [32:0] t;
    unique case (state_r)
      vna_pkg::N_IDLE: if (req.start) begin
        neg_r[0] <= req.x[34];
        neg_r[1] <= req.y[34];
        neg_r[2] <= req.z[34];
        mag_r[0] <= req.x[34] ? 35'(-req.x) : 35'(req.x);
        mag_r[1] <= req.y[34] ? 35'(-req.y) : 35'(req.y);
        mag_r[2] <= req.z[34] ? 35'(-req.z) : 35'(req.z);
      end
      vna_pkg::N_SHIFT: begin
        zero_r <= (mx == '0);
        for (int i = 0; i < 3; i++) begin
          mag_r[i] <= mag_r[i] >> sh;
          q_r[i]   <= '0;
        end
        sum_r <= '0;
        cnt_r <= '0;
        res_r <= '0;
        bit_r <= 63'(1) << 62;
      end
      vna_pkg::N_SQ: begin
        sum_r <= sum_r + 62'(sq);
        cnt_r <= cnt_r + 4'd1;
      end
      vna_pkg::N_SQRT: begin
        if (ge) begin
          sum_r <= 62'(64'(sum_r) - trial);
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      vna_pkg::N_DINIT: begin
        for (int i = 0; i < 3; i++) begin
          num = {1'b0, mag_r[i][29:0], 15'b0} + 46'(res_r[30:0]);
          rq_r[i] <= 32'(num[45:15]);
          lo_r[i] <= num[14:0];
        end
        cnt_r <= '0;
      end
      vna_pkg::N_DIV: begin
        for (int i = 0; i < 3; i++) begin
          t = {rq_r[i], lo_r[i][14]};
          if (t >= den) begin
            rq_r[i] <= 32'(t - den);
            q_r[i]  <= {q_r[i][13:0], 1'b1};
          end else begin
            rq_r[i] <= t[31:0];
            q_r[i]  <= {q_r[i][13:0], 1'b0};
          end
          lo_r[i] <= {lo_r[i][13:0], 1'b0};
        end
        cnt_r <= cnt_r + 4'd1;
      end
      default: ;
    endcase
  end

  always_comb begin
    rsp.done = (state_r == vna_pkg::N_DONE);
    rsp.zero = zero_r;
    rsp.x    = neg_r[0] ? 16'(-{1'b0, q_r[0]}) : {1'b0, q_r[0]};
    rsp.y    = neg_r[1] ? 16'(-{1'b0, q_r[1]}) : {1'b0, q_r[1]};
    rsp.z    = neg_r[2] ? 16'(-{1'b0, q_r[2]}) : {1'b0, q_r[2]};
  end
endmodule

[rtl/vna_checker.sv]
`include "assert_macros.svh"

module vna_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_action,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_last,
  input logic [15:0] norm_x,
  input logic [15:0] norm_y,
  input logic [15:0] norm_z
);
  logic nx_ok, ny_ok, nz_ok, tri_acc;

  assign nx_ok   = ($signed(norm_x) <= vna_pkg::UNIT_Q14) &&
                   ($signed(norm_x) >= -vna_pkg::UNIT_Q14);
  assign ny_ok   = ($signed(norm_y) <= vna_pkg::UNIT_Q14) &&
                   ($signed(norm_y) >= -vna_pkg::UNIT_Q14);
  assign nz_ok   = ($signed(norm_z) <= vna_pkg::UNIT_Q14) &&
                   ($signed(norm_z) >= -vna_pkg::UNIT_Q14);
  assign tri_acc = in_valid && in_ready && (in_action == vna_pkg::ACT_TRI);

  `VNA_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped")
  `VNA_ASSERT(a_norm_range, clk, rst_n, out_valid |-> (nx_ok && ny_ok && nz_ok), "normal out of range")
  `VNA_ASSERT(a_tri_busy, clk, rst_n, tri_acc |=> !in_ready, "triangle not held busy")
  `VNA_ASSERT(a_mid_busy, clk, rst_n, out_valid && !out_last |-> !in_ready, "taken mid triangle")
  `VNA_ASSERT_ALWAYS(a_rst_clear, clk, !rst_n |=> !out_valid, "output valid after reset")
endmodule

bind vertex_normal_accumulator vna_checker u_vna_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_if.valid), .in_ready(in_if.ready), .in_action(in_if.action),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .out_last(out_if.last),
  .norm_x(out_if.norm_x), .norm_y(out_if.norm_y), .norm_z(out_if.norm_z)
);

[dv/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Code 3 is unused by the block: it must be swallowed without a result.
  localparam logic [1:0] ACT_SPARE   = 2'd3;
  localparam int         CYCLE_LIMIT = 800000;
  localparam int         RAND_ITEMS  = 152;

  typedef struct {
    logic [1:0]                action;
    logic [vna_pkg::IDX_W-1:0] vertex_index;
    logic signed [15:0]        pos_x, pos_y, pos_z;
    logic [vna_pkg::IDX_W-1:0] corner_a, corner_b, corner_c;
  } vna_item_t;

  typedef struct {
    logic [vna_pkg::IDX_W-1:0] vertex;
    logic signed [15:0]        nx, ny, nz;
    logic                      degenerate;
    logic                      last;
  } vna_normal_t;

  // Mirror of both vertex tables plus the queue of normals still owed.
  class normal_tracker;
    logic signed [15:0] pos_tab[vna_pkg::NUM_VERT][3];
    logic signed [15:0] nrm_tab[vna_pkg::NUM_VERT][3];
    vna_normal_t        owed[$];
    int                 errors;
    int                 checked;
    int                 accepted;

    function automatic longint unsigned root_floor(longint unsigned n);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n   -= res + bitv;
          res  = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    // Q1.14 unit vector; returns 0 for the zero vector.
    function automatic bit unitise(input longint v[3], output int n[3]);
      longint unsigned mag[3];
      longint unsigned mx, acc, len, q;
      mx  = 0;
      acc = 0;
      for (int i = 0; i < 3; i++) begin
        n[i]   = 0;
        mag[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
        if (mag[i] > mx) mx = mag[i];
      end
      if (mx == 0) return 0;
      while (mx >= (64'd1 << 30)) begin
        mx >>= 1;
        for (int i = 0; i < 3; i++) mag[i] >>= 1;
      end
      for (int i = 0; i < 3; i++) acc += mag[i] * mag[i];
      len = root_floor(acc);
      for (int i = 0; i < 3; i++) begin
        q    = (mag[i] * vna_pkg::UNIT_Q14 * 2 + len) / (2 * len);
        n[i] = (v[i] < 0) ? -int'(q) : int'(q);
      end
      return 1;
    endfunction

    function void owe(int vert, logic signed [15:0] v[3], bit degen, bit lst);
      vna_normal_t r;
      r.vertex     = vert[vna_pkg::IDX_W-1:0];
      r.nx         = v[0];
      r.ny         = v[1];
      r.nz         = v[2];
      r.degenerate = degen;
      r.last       = lst;
      owed.insert(owed.size(), r);
    endfunction

    function void note_item(vna_item_t it);
      int     c[3];
      longint e1[3], e2[3], cr[3], s[3];
      int     face[3], n[3];
      bit     flat, zero;
      accepted++;
      case (it.action)
        vna_pkg::ACT_LOAD: begin
          pos_tab[it.vertex_index][0] = it.pos_x;
          pos_tab[it.vertex_index][1] = it.pos_y;
          pos_tab[it.vertex_index][2] = it.pos_z;
          for (int i = 0; i < 3; i++) nrm_tab[it.vertex_index][i] = '0;
        end
        vna_pkg::ACT_READ: owe(it.vertex_index, nrm_tab[it.vertex_index], 0, 1);
        vna_pkg::ACT_TRI: begin
          c[0] = it.corner_a;
          c[1] = it.corner_b;
          c[2] = it.corner_c;
          for (int i = 0; i < 3; i++) begin
            e1[i] = longint'(pos_tab[c[1]][i]) - longint'(pos_tab[c[0]][i]);
            e2[i] = longint'(pos_tab[c[2]][i]) - longint'(pos_tab[c[0]][i]);
          end
          cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
          cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
          cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
          flat  = !unitise(cr, face);
          // corners in order: a repeated vertex sees its earlier update
          for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) s[i] = longint'(nrm_tab[c[k]][i]) + face[i];
            zero = !unitise(s, n);
            for (int i = 0; i < 3; i++) nrm_tab[c[k]][i] = n[i][15:0];
            owe(c[k], nrm_tab[c[k]], flat || zero, k == 2);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_normal(vna_normal_t got);
      vna_normal_t exp_r;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] unexpected normal for vertex %0d", $realtime, got.vertex);
        return;
      end
      exp_r = owed.pop_front();
      checked++;
      if (got.vertex !== exp_r.vertex || got.nx !== exp_r.nx || got.ny !== exp_r.ny ||
          got.nz !== exp_r.nz || got.degenerate !== exp_r.degenerate ||
          got.last !== exp_r.last) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] normal mismatch: exp v%0d (%0d,%0d,%0d) dg%0b l%0b,",
                   $realtime, exp_r.vertex, exp_r.nx, exp_r.ny, exp_r.nz,
                   exp_r.degenerate, exp_r.last,
                   " got v%0d (%0d,%0d,%0d) dg%0b l%0b", got.vertex, got.nx,
                   got.ny, got.nz, got.degenerate, got.last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycle_count = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   loaded[$];            // vertices whose tables hold defined data
  vna_item_t directed[$];

  normal_tracker tracker = new();

  vna_in_if  in_if();
  vna_out_if out_if();

  vertex_normal_accumulator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result-side back-pressure.
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Both channels are sampled at the edge, pre-update values only.
  always @(posedge clk) begin
    vna_item_t   it;
    vna_normal_t r;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        it.action       = in_if.action;
        it.vertex_index = in_if.vertex_index;
        it.pos_x        = in_if.pos_x;
        it.pos_y        = in_if.pos_y;
        it.pos_z        = in_if.pos_z;
        it.corner_a     = in_if.corner_a;
        it.corner_b     = in_if.corner_b;
        it.corner_c     = in_if.corner_c;
        tracker.note_item(it);
      end
      if (out_if.valid && out_if.ready) begin
        r.vertex     = out_if.out_vertex;
        r.nx         = out_if.norm_x;
        r.ny         = out_if.norm_y;
        r.nz         = out_if.norm_z;
        r.degenerate = out_if.degenerate;
        r.last       = out_if.last;
        tracker.check_normal(r);
      end
    end
  end

  // valid stays high between back-to-back transactions; it is only lowered
  // on an idle cycle, so it never sees two assignments in one step
  task automatic send_item(vna_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.action       <= it.action;
    in_if.vertex_index <= it.vertex_index;
    in_if.pos_x        <= it.pos_x;
    in_if.pos_y        <= it.pos_y;
    in_if.pos_z        <= it.pos_z;
    in_if.corner_a     <= it.corner_a;
    in_if.corner_b     <= it.corner_b;
    in_if.corner_c     <= it.corner_c;
    do @(posedge clk); while (!in_if.ready);
  endtask

  function automatic vna_item_t make_item(logic [1:0] act, int vi, int px, int py, int pz,
                                          int ca, int cb, int cc);
    vna_item_t it;
    it.action       = act;
    it.vertex_index = vi[vna_pkg::IDX_W-1:0];
    it.pos_x        = px[15:0];
    it.pos_y        = py[15:0];
    it.pos_z        = pz[15:0];
    it.corner_a     = ca[vna_pkg::IDX_W-1:0];
    it.corner_b     = cb[vna_pkg::IDX_W-1:0];
    it.corner_c     = cc[vna_pkg::IDX_W-1:0];
    if (act == vna_pkg::ACT_LOAD) loaded.insert(loaded.size(), vi);
    return it;
  endfunction

  function automatic void stage(vna_item_t it);
    directed.insert(directed.size(), it);
  endfunction

  function automatic int pick_vertex();
    return loaded[$urandom_range(loaded.size() - 1)];
  endfunction

  // Triangles over loaded vertices most often; junk in the unused fields.
  function automatic vna_item_t random_item();
    vna_item_t it;
    int        roll, ca, cb, cc, coord;
    roll  = $urandom_range(99);
    ca    = pick_vertex();
    cb    = pick_vertex();
    cc    = pick_vertex();
    coord = ($urandom_range(3) == 0) ? 1024 : 32768;
    if (roll < 25) begin
      it = make_item(vna_pkg::ACT_LOAD, $urandom_range(vna_pkg::NUM_VERT - 1),
                     $urandom_range(2 * coord - 1) - coord,
                     $urandom_range(2 * coord - 1) - coord,
                     $urandom_range(2 * coord - 1) - coord,
                     $urandom, $urandom, $urandom);
    end else if (roll < 72) begin
      if ($urandom_range(9) == 0) cb = ca;      // zero-area corner
      else if ($urandom_range(9) == 0) cc = cb; // repeated corner later on
      it = make_item(vna_pkg::ACT_TRI, $urandom, $urandom, $urandom, $urandom, ca, cb, cc);
    end else if (roll < 95) begin
      it = make_item(vna_pkg::ACT_READ, pick_vertex(), $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom);
    end else begin
      it = make_item(ACT_SPARE, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom);
    end
    return it;
  endfunction

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (tracker.owed.size() != 0) @(posedge clk);
  endtask

  initial begin
    int        idle_plan[4]  = '{0, 68, 0, 29};
    int        stall_plan[4] = '{0, 0, 68, 29};

    in_if.valid        = 1'b0;
    in_if.action       = vna_pkg::ACT_LOAD;
    in_if.vertex_index = '0;
    in_if.pos_x        = '0;
    in_if.pos_y        = '0;
    in_if.pos_z        = '0;
    in_if.corner_a     = '0;
    in_if.corner_b     = '0;
    in_if.corner_c     = '0;
    out_if.ready       = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: coordinate extremes, a flat triangle, a face that cancels the
    // stored normals, repeated corners, reads, the spare code and a reload.
    stage(make_item(vna_pkg::ACT_LOAD, 0, -32768, -32768, -32768, 0, 0, 0));
    stage(make_item(vna_pkg::ACT_LOAD, 1023, 32767, 32767, 32767, 1023, 1023, 1023));
    stage(make_item(vna_pkg::ACT_LOAD, 5, 32767, -32768, 0, 0, 0, 0));
    stage(make_item(vna_pkg::ACT_LOAD, 341, 0, 0, 0, 0, 0, 0));
    stage(make_item(vna_pkg::ACT_LOAD, 10, 256, 0, 0, 0, 0, 0));
    stage(make_item(vna_pkg::ACT_LOAD, 20, 0, 256, 0, 0, 0, 0));
    stage(make_item(vna_pkg::ACT_TRI, 0, 0, 0, 0, 341, 10, 20));
    stage(make_item(vna_pkg::ACT_TRI, 0, 0, 0, 0, 341, 20, 10));
    stage(make_item(vna_pkg::ACT_TRI, 1023, 0, 0, 0, 0, 1023, 5));
    stage(make_item(vna_pkg::ACT_TRI, 0, 0, 0, 0, 341, 341, 10));
    stage(make_item(vna_pkg::ACT_TRI, 0, 0, 0, 0, 10, 10, 10));
    stage(make_item(vna_pkg::ACT_TRI, 0, 0, 0, 0, 1023, 0, 5));
    stage(make_item(vna_pkg::ACT_READ, 341, 0, 0, 0, 0, 0, 0));
    stage(make_item(vna_pkg::ACT_READ, 1023, -1, -1, -1, 1023, 1023, 1023));
    stage(make_item(vna_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0));
    stage(make_item(ACT_SPARE, 1023, -1, -1, -1, 1023, 1023, 1023));
    stage(make_item(vna_pkg::ACT_TRI, 0, 0, 0, 0, 5, 1023, 0));
    stage(make_item(vna_pkg::ACT_LOAD, 10, -256, 512, -768, 0, 0, 0));
    stage(make_item(vna_pkg::ACT_READ, 10, 0, 0, 0, 0, 0, 0));
    stage(make_item(vna_pkg::ACT_TRI, 0, 0, 0, 0, 20, 10, 1023));
    foreach (directed[i]) send_item(directed[i]);
    // hold-off: nothing new until every owed normal is back
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_plan[ph];
      recv_stall_pct = stall_plan[ph];
      repeat (RAND_ITEMS / 4) send_item(random_item());
      wait_drained();
    end

    recv_stall_pct = 0;
    repeat (300) @(posedge clk);
    $display("Ran %0d transactions (directed extremes, flat and cancelling faces,",
             tracker.accepted);
    $display("  repeated corners, reads, spare code) and checked %0d normals.",
             tracker.checked);
    if (tracker.errors == 0 && tracker.owed.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
